FILE: sv/abkf_pkg.sv
package abkf_pkg;

  // Fixed point format and filter dimensions.
  localparam int NUM_AXES  = 3;
  localparam int FRAC_BITS = 24;
  localparam int FX_W      = 40;
  localparam int AXIS_W    = 2;
  localparam int CFG_W     = 25;
  localparam int CFG_IDX_W = 2;

  // Sequenced multiplier: magnitude of A times MUL_STEPS chunks of B.
  localparam int MUL_AW    = FX_W + 1;
  localparam int MUL_CHUNK = 14;
  localparam int MUL_STEPS = 3;
  localparam int MUL_BW    = MUL_CHUNK * MUL_STEPS;
  localparam int MUL_PP_W  = MUL_AW + MUL_CHUNK;
  localparam int PROD_W    = MUL_AW + MUL_BW;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS);

  // Restoring divider: numerator magnitude shifted up by FRAC_BITS.
  localparam int DVD_W     = FX_W + 1 + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DVD_W);

  typedef logic signed [FX_W-1:0] fx_t;
  typedef logic signed [FX_W:0]   wide_t;
  typedef logic signed [FX_W+3:0] sum_t;
  typedef logic [CFG_W-1:0]       cfg_t;
  typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;
  typedef logic [3:0]             step_t;

  localparam fx_t FX_MAX = {1'b0, {(FX_W-1){1'b1}}};
  localparam fx_t FX_MIN = {1'b1, {(FX_W-1){1'b0}}};

  // Configuration register indexes and reset values.
  localparam cfg_idx_t CFG_ANGLE_NOISE   = 2'd0;
  localparam cfg_idx_t CFG_BIAS_NOISE    = 2'd1;
  localparam cfg_idx_t CFG_MEASURE_NOISE = 2'd2;
  localparam cfg_t ANGLE_NOISE_RESET   = 25'd16777;
  localparam cfg_t BIAS_NOISE_RESET    = 25'd50332;
  localparam cfg_t MEASURE_NOISE_RESET = 25'd50332;

  // Multiply steps of one update, in issue order.
  localparam step_t STEP_RATE_DT   = 4'd0;
  localparam step_t STEP_DT_C11    = 4'd1;
  localparam step_t STEP_DT_C10    = 4'd2;
  localparam step_t STEP_DT_T      = 4'd3;
  localparam step_t STEP_K0_INNOV  = 4'd4;
  localparam step_t STEP_K1_INNOV  = 4'd5;
  localparam step_t STEP_K0_P00    = 4'd6;
  localparam step_t STEP_K0_P01    = 4'd7;
  localparam step_t STEP_K1_P00    = 4'd8;
  localparam step_t STEP_K1_P01    = 4'd9;

  typedef struct packed {
    logic  load;
    logic  mul_start;
    logic  commit;
    logic  div_start;
    logic  write_back;
    logic  write_zero;
    step_t step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic out_free;
    logic axis_bad;
  } ctrl_status_t;

  // Saturate a wider signed sum to the 40-bit format.
  function automatic fx_t sat_fx(input sum_t v);
    fx_t r;
    if (v > sum_t'(FX_MAX)) begin
      r = FX_MAX;
    end else if (v < sum_t'(FX_MIN)) begin
      r = FX_MIN;
    end else begin
      r = v[FX_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: sv/abkf_ifs.sv
// Input channel: one sample for one axis.
interface abkf_in_if;
  logic                         valid;
  logic                         ready;
  logic [abkf_pkg::AXIS_W-1:0]  axis;
  abkf_pkg::fx_t                gyro_rate;
  abkf_pkg::fx_t                accel_angle;
  logic [abkf_pkg::CFG_W-1:0]   time_step;

  modport source (output valid, axis, gyro_rate, accel_angle, time_step, input ready);
  modport sink   (input valid, axis, gyro_rate, accel_angle, time_step, output ready);
endinterface

// Output channel: updated estimates for the axis.
interface abkf_out_if;
  logic          valid;
  logic          ready;
  abkf_pkg::fx_t angle_out;
  abkf_pkg::fx_t bias_out;
  abkf_pkg::fx_t unbiased_rate;

  modport source (output valid, angle_out, bias_out, unbiased_rate, input ready);
  modport sink   (input valid, angle_out, bias_out, unbiased_rate, output ready);
endinterface

FILE: sv/abkf_mul.sv
module abkf_mul (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  abkf_pkg::wide_t       a,
  input  abkf_pkg::wide_t       b,
  output logic                  done,
  output abkf_pkg::fx_t         res
);

  logic                                busy;
  logic                                fin;
  logic [abkf_pkg::MUL_CNT_W-1:0]      cnt;
  logic                                neg;
  logic [abkf_pkg::MUL_AW-1:0]         ma;
  logic [abkf_pkg::MUL_BW-1:0]         mb;
  logic [abkf_pkg::PROD_W-1:0]         acc;
  logic [abkf_pkg::MUL_PP_W-1:0]       pp;
  logic [abkf_pkg::PROD_W:0]           rnd;
  logic [abkf_pkg::PROD_W-abkf_pkg::FRAC_BITS:0] mq;
  abkf_pkg::fx_t                       res_next;

  // Partial product of A with the top chunk of B.
  always_comb begin
    pp = ma * mb[abkf_pkg::MUL_BW-1 -: abkf_pkg::MUL_CHUNK];
  end

  // Round to nearest on the magnitude, ties away from zero, then saturate.
  always_comb begin
    rnd = {1'b0, acc} + ((abkf_pkg::PROD_W+1)'(1) << (abkf_pkg::FRAC_BITS - 1));
    mq  = rnd[abkf_pkg::PROD_W:abkf_pkg::FRAC_BITS];
    if (neg) begin
      if (mq > $bits(mq)'(abkf_pkg::FX_MAX) + $bits(mq)'(1)) begin
        res_next = abkf_pkg::FX_MIN;
      end else begin
        res_next = abkf_pkg::fx_t'(-mq[abkf_pkg::FX_W-1:0]);
      end
    end else begin
      if (mq > $bits(mq)'(abkf_pkg::FX_MAX)) begin
        res_next = abkf_pkg::FX_MAX;
      end else begin
        res_next = abkf_pkg::fx_t'(mq[abkf_pkg::FX_W-1:0]);
      end
    end
  end

  // Control of the chunk sequence.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == abkf_pkg::MUL_CNT_W'(abkf_pkg::MUL_STEPS - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Operand magnitudes and the shift-accumulate.
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= a[abkf_pkg::FX_W] ^ b[abkf_pkg::FX_W];
      ma  <= a[abkf_pkg::FX_W] ? abkf_pkg::MUL_AW'(-a) : abkf_pkg::MUL_AW'(a);
      mb  <= b[abkf_pkg::FX_W] ? abkf_pkg::MUL_BW'(-b) :
             abkf_pkg::MUL_BW'(unsigned'(b));
      acc <= '0;
    end else if (busy) begin
      acc <= (acc << abkf_pkg::MUL_CHUNK) + abkf_pkg::PROD_W'(pp);
      mb  <= mb << abkf_pkg::MUL_CHUNK;
    end
    if (fin) begin
      res <= res_next;
    end
  end

endmodule

FILE: sv/abkf_div.sv
module abkf_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  abkf_pkg::fx_t   num,
  input  abkf_pkg::wide_t den,
  output logic            done,
  output abkf_pkg::fx_t   quo
);

  logic                              busy;
  logic                              fin;
  logic [abkf_pkg::DIV_CNT_W-1:0]    cnt;
  logic                              neg;
  logic [abkf_pkg::FX_W:0]           md;
  logic [abkf_pkg::DVD_W-1:0]        dvd;
  logic [abkf_pkg::FX_W:0]           rem;
  logic [abkf_pkg::DVD_W-1:0]        q;
  logic [abkf_pkg::FX_W+1:0]         trial;
  logic                              ge;
  logic [abkf_pkg::FX_W-1:0]         mn;
  abkf_pkg::fx_t                     quo_next;

  // One quotient bit a cycle: shift in the next dividend bit and compare.
  always_comb begin
    trial = {rem, dvd[abkf_pkg::DVD_W-1]};
    ge    = trial >= {1'b0, md};
    mn    = num[abkf_pkg::FX_W-1] ? abkf_pkg::FX_W'(-num) : abkf_pkg::FX_W'(num);
  end

  // Saturate the unsigned quotient and apply the sign.
  always_comb begin
    if (neg) begin
      if (q > abkf_pkg::DVD_W'(abkf_pkg::FX_MAX) + abkf_pkg::DVD_W'(1)) begin
        quo_next = abkf_pkg::FX_MIN;
      end else begin
        quo_next = abkf_pkg::fx_t'(-q[abkf_pkg::FX_W-1:0]);
      end
    end else begin
      if (q > abkf_pkg::DVD_W'(abkf_pkg::FX_MAX)) begin
        quo_next = abkf_pkg::FX_MAX;
      end else begin
        quo_next = abkf_pkg::fx_t'(q[abkf_pkg::FX_W-1:0]);
      end
    end
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == abkf_pkg::DIV_CNT_W'(abkf_pkg::DVD_W - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Remainder, quotient and dividend shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num[abkf_pkg::FX_W-1] ^ den[abkf_pkg::FX_W];
      md  <= den[abkf_pkg::FX_W] ? (abkf_pkg::FX_W+1)'(-den) :
             (abkf_pkg::FX_W+1)'(unsigned'(den));
      dvd <= {1'b0, mn, {abkf_pkg::FRAC_BITS{1'b0}}};
      rem <= '0;
      q   <= '0;
    end else if (busy) begin
      rem <= ge ? abkf_pkg::FX_W'(trial - {1'b0, md}) + (abkf_pkg::FX_W+1)'(0) :
             trial[abkf_pkg::FX_W:0];
      q   <= {q[abkf_pkg::DVD_W-2:0], ge};
      dvd <= dvd << 1;
    end
    if (fin) begin
      quo <= quo_next;
    end
  end

endmodule

FILE: sv/abkf_ctrl.sv
module abkf_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  abkf_pkg::ctrl_status_t status,
  output abkf_pkg::ctrl_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_MUL_GO   = 3'd1;
  localparam logic [2:0] S_MUL_WAIT = 3'd2;
  localparam logic [2:0] S_DIV_GO   = 3'd3;
  localparam logic [2:0] S_DIV_WAIT = 3'd4;
  localparam logic [2:0] S_WRITE    = 3'd5;
  localparam logic [2:0] S_BAD      = 3'd6;

  logic [2:0]      state;
  logic [2:0]      state_next;
  abkf_pkg::step_t step;
  abkf_pkg::step_t step_next;

  // Commands for the datapath in each state.
  always_comb begin
    cmd            = '0;
    cmd.step       = step;
    in_ready       = (state == S_IDLE);
    cmd.load       = in_valid && (state == S_IDLE);
    cmd.mul_start  = (state == S_MUL_GO);
    cmd.commit     = (state == S_MUL_WAIT) && status.mul_done;
    cmd.div_start  = (state == S_DIV_GO);
    cmd.write_back = (state == S_WRITE) && status.out_free;
    cmd.write_zero = (state == S_BAD) && status.out_free;
  end

  // Step sequence: four prediction products, the gains, six update products.
  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      S_IDLE: begin
        if (cmd.load) begin
          state_next = status.axis_bad ? S_BAD : S_MUL_GO;
          step_next  = abkf_pkg::STEP_RATE_DT;
        end
      end
      S_MUL_GO: begin
        state_next = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (status.mul_done) begin
          if (step == abkf_pkg::STEP_DT_T) begin
            state_next = S_DIV_GO;
          end else if (step == abkf_pkg::STEP_K1_P01) begin
            state_next = S_WRITE;
          end else begin
            state_next = S_MUL_GO;
            step_next  = step + 1'b1;
          end
        end
      end
      S_DIV_GO: begin
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (status.div_done) begin
          state_next = S_MUL_GO;
          step_next  = abkf_pkg::STEP_K0_INNOV;
        end
      end
      S_WRITE: begin
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      S_BAD: begin
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= abkf_pkg::STEP_RATE_DT;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // A result is only written into a free output register.
  a_write_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.write_back || cmd.write_zero) |-> status.out_free)
    else $error("result written over a pending transaction");

  // The last update product leads straight to the write-back.
  a_last_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL_WAIT && status.mul_done && step == abkf_pkg::STEP_K1_P01)
    |=> (state == S_WRITE))
    else $error("sequence did not end in write-back");

  // The divider finishes only while it is awaited.
  a_div_expected: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> (state == S_DIV_WAIT))
    else $error("unexpected divider completion");

endmodule

FILE: sv/abkf_dpath.sv
module abkf_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  abkf_pkg::ctrl_cmd_t           cmd,
  output abkf_pkg::ctrl_status_t        status,
  input  logic                          cfg_we,
  input  abkf_pkg::cfg_idx_t            cfg_index,
  input  abkf_pkg::cfg_t                cfg_data,
  input  logic [abkf_pkg::AXIS_W-1:0]   in_axis,
  input  abkf_pkg::fx_t                 in_gyro_rate,
  input  abkf_pkg::fx_t                 in_accel_angle,
  input  abkf_pkg::cfg_t                in_time_step,
  output logic                          out_valid,
  input  logic                          out_ready,
  output abkf_pkg::fx_t                 angle_out,
  output abkf_pkg::fx_t                 bias_out,
  output abkf_pkg::fx_t                 unbiased_rate
);

  // Per-axis filter state.
  abkf_pkg::fx_t angle_mem [abkf_pkg::NUM_AXES];
  abkf_pkg::fx_t bias_mem  [abkf_pkg::NUM_AXES];
  abkf_pkg::fx_t c00_mem   [abkf_pkg::NUM_AXES];
  abkf_pkg::fx_t c01_mem   [abkf_pkg::NUM_AXES];
  abkf_pkg::fx_t c10_mem   [abkf_pkg::NUM_AXES];
  abkf_pkg::fx_t c11_mem   [abkf_pkg::NUM_AXES];

  abkf_pkg::cfg_t angle_noise, bias_noise, measure_noise;

  logic [abkf_pkg::AXIS_W-1:0] axis;
  abkf_pkg::cfg_t  dt;
  abkf_pkg::fx_t   acc, urate, x, b, c00, c01, c10, c11;
  abkf_pkg::fx_t   p00, p01, p10, p11, k0, k1;
  abkf_pkg::wide_t diff, t, s00, innov;
  abkf_pkg::wide_t diff_next, den, dt_w;
  logic            den_zero;

  abkf_pkg::wide_t mul_a, mul_b;
  abkf_pkg::fx_t   mul_res, q0, q1;
  logic            mul_done, div_done, div1_done;

  // Status towards the controller.
  always_comb begin
    status.mul_done = mul_done;
    status.div_done = div_done;
    status.out_free = !out_valid || out_ready;
    status.axis_bad = int'(in_axis) >= abkf_pkg::NUM_AXES;
  end

  always_comb begin
    diff_next = abkf_pkg::wide_t'(in_gyro_rate) - abkf_pkg::wide_t'(bias_mem[in_axis]);
    den       = abkf_pkg::wide_t'(p00) + abkf_pkg::wide_t'(measure_noise);
    dt_w      = abkf_pkg::wide_t'(dt);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (cmd.step)
      abkf_pkg::STEP_RATE_DT: begin
        mul_a = dt_w; mul_b = diff;
      end
      abkf_pkg::STEP_DT_C11: begin
        mul_a = dt_w; mul_b = abkf_pkg::wide_t'(c11);
      end
      abkf_pkg::STEP_DT_C10: begin
        mul_a = dt_w; mul_b = abkf_pkg::wide_t'(c10);
      end
      abkf_pkg::STEP_DT_T: begin
        mul_a = dt_w; mul_b = t;
      end
      abkf_pkg::STEP_K0_INNOV: begin
        mul_a = abkf_pkg::wide_t'(k0); mul_b = innov;
      end
      abkf_pkg::STEP_K1_INNOV: begin
        mul_a = abkf_pkg::wide_t'(k1); mul_b = innov;
      end
      abkf_pkg::STEP_K0_P00: begin
        mul_a = abkf_pkg::wide_t'(k0); mul_b = abkf_pkg::wide_t'(p00);
      end
      abkf_pkg::STEP_K0_P01: begin
        mul_a = abkf_pkg::wide_t'(k0); mul_b = abkf_pkg::wide_t'(p01);
      end
      abkf_pkg::STEP_K1_P00: begin
        mul_a = abkf_pkg::wide_t'(k1); mul_b = abkf_pkg::wide_t'(p00);
      end
      abkf_pkg::STEP_K1_P01: begin
        mul_a = abkf_pkg::wide_t'(k1); mul_b = abkf_pkg::wide_t'(p01);
      end
      default: begin
        mul_a = '0; mul_b = '0;
      end
    endcase
  end

  abkf_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  // Both gains share the denominator and run side by side.
  abkf_div u_div0 (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (p00),
    .den   (den),
    .done  (div_done),
    .quo   (q0)
  );

  abkf_div u_div1 (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (p10),
    .den   (den),
    .done  (div1_done),
    .quo   (q1)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_noise   <= abkf_pkg::ANGLE_NOISE_RESET;
      bias_noise    <= abkf_pkg::BIAS_NOISE_RESET;
      measure_noise <= abkf_pkg::MEASURE_NOISE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        abkf_pkg::CFG_ANGLE_NOISE:   angle_noise   <= cfg_data;
        abkf_pkg::CFG_BIAS_NOISE:    bias_noise    <= cfg_data;
        abkf_pkg::CFG_MEASURE_NOISE: measure_noise <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Working registers: load, commit of each product, gains.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      axis  <= in_axis;
      dt    <= in_time_step;
      acc   <= in_accel_angle;
      x     <= angle_mem[in_axis];
      b     <= bias_mem[in_axis];
      c00   <= c00_mem[in_axis];
      c01   <= c01_mem[in_axis];
      c10   <= c10_mem[in_axis];
      c11   <= c11_mem[in_axis];
      diff  <= diff_next;
      urate <= abkf_pkg::sat_fx(abkf_pkg::sum_t'(diff_next));
    end
    if (cmd.commit) begin
      case (cmd.step)
        abkf_pkg::STEP_RATE_DT, abkf_pkg::STEP_K0_INNOV: begin
          x <= abkf_pkg::sat_fx(abkf_pkg::sum_t'(x) + abkf_pkg::sum_t'(mul_res));
        end
        abkf_pkg::STEP_DT_C11: begin
          t   <= abkf_pkg::wide_t'(c01) - abkf_pkg::wide_t'(mul_res);
          p10 <= abkf_pkg::sat_fx(abkf_pkg::sum_t'(c10) - abkf_pkg::sum_t'(mul_res));
        end
        abkf_pkg::STEP_DT_C10: begin
          s00 <= abkf_pkg::wide_t'(c00) - abkf_pkg::wide_t'(mul_res);
        end
        abkf_pkg::STEP_DT_T: begin
          p00 <= abkf_pkg::sat_fx(abkf_pkg::sum_t'(s00) - abkf_pkg::sum_t'(mul_res)
                                  + abkf_pkg::sum_t'(angle_noise));
          p01 <= abkf_pkg::sat_fx(abkf_pkg::sum_t'(t));
          p11 <= abkf_pkg::sat_fx(abkf_pkg::sum_t'(c11) + abkf_pkg::sum_t'(bias_noise));
        end
        abkf_pkg::STEP_K1_INNOV: begin
          b <= abkf_pkg::sat_fx(abkf_pkg::sum_t'(b) + abkf_pkg::sum_t'(mul_res));
        end
        abkf_pkg::STEP_K0_P00: begin
          c00 <= abkf_pkg::sat_fx(abkf_pkg::sum_t'(p00) - abkf_pkg::sum_t'(mul_res));
        end
        abkf_pkg::STEP_K0_P01: begin
          c01 <= abkf_pkg::sat_fx(abkf_pkg::sum_t'(p01) - abkf_pkg::sum_t'(mul_res));
        end
        abkf_pkg::STEP_K1_P00: begin
          c10 <= abkf_pkg::sat_fx(abkf_pkg::sum_t'(p10) - abkf_pkg::sum_t'(mul_res));
        end
        abkf_pkg::STEP_K1_P01: begin
          c11 <= abkf_pkg::sat_fx(abkf_pkg::sum_t'(p11) - abkf_pkg::sum_t'(mul_res));
        end
        default: begin
        end
      endcase
    end
    if (cmd.div_start) begin
      den_zero <= (den == '0);
      innov    <= abkf_pkg::wide_t'(acc) - abkf_pkg::wide_t'(x);
    end
    // A zero denominator leaves both gains at zero.
    if (div_done && div1_done) begin
      k0 <= den_zero ? '0 : q0;
      k1 <= den_zero ? '0 : q1;
    end
  end

  // Per-axis state write-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < abkf_pkg::NUM_AXES; i++) begin
        angle_mem[i] <= '0;
        bias_mem[i]  <= '0;
        c00_mem[i]   <= '0;
        c01_mem[i]   <= '0;
        c10_mem[i]   <= '0;
        c11_mem[i]   <= '0;
      end
    end else if (cmd.write_back) begin
      angle_mem[axis] <= x;
      bias_mem[axis]  <= b;
      c00_mem[axis]   <= c00;
      c01_mem[axis]   <= c01;
      c10_mem[axis]   <= c10;
      c11_mem[axis]   <= c11;
    end
  end

  // Output register: holds one result until its transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.write_back || cmd.write_zero) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_back) begin
      angle_out     <= x;
      bias_out      <= b;
      unbiased_rate <= urate;
    end else if (cmd.write_zero) begin
      angle_out     <= '0;
      bias_out      <= '0;
      unbiased_rate <= '0;
    end
  end

endmodule

FILE: sv/angle_bias_kalman_filter_core.sv
// Channel   Direction  Payload
// in_ch     sink       axis, gyro_rate, accel_angle, time_step
// out_ch    source     angle_out, bias_out, unbiased_rate
// cfg       write      cfg_we, cfg_index, cfg_data (angle, bias, measurement noise)
//
// One update runs ten products on one shared multiplier (three 41x14
// chunks plus rounding each) and the gain division, a restoring divider
// retiring one quotient bit per cycle (65 bits).
// An item with an axis out of range returns zeros.
// Reset is synchronous; it zeroes the state of all axes and loads the noise defaults.
// A finished result waits in the output register; the next item is taken meanwhile.
module angle_bias_kalman_filter_core (
  input  logic                clk,
  input  logic                rst,
  abkf_in_if.sink             in_ch,
  abkf_out_if.source          out_ch,
  input  logic                cfg_we,
  input  abkf_pkg::cfg_idx_t  cfg_index,
  input  abkf_pkg::cfg_t      cfg_data
);

  abkf_pkg::ctrl_cmd_t    cmd;
  abkf_pkg::ctrl_status_t status;

  abkf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  abkf_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_axis        (in_ch.axis),
    .in_gyro_rate   (in_ch.gyro_rate),
    .in_accel_angle (in_ch.accel_angle),
    .in_time_step   (in_ch.time_step),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .angle_out      (out_ch.angle_out),
    .bias_out       (out_ch.bias_out),
    .unbiased_rate  (out_ch.unbiased_rate)
  );

endmodule

FILE: verif/tb_angle_bias_kalman_filter_core.sv
module tb_angle_bias_kalman_filter_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] big_t;

  // One expected filter output.
  typedef struct {
    abkf_pkg::fx_t angle;
    abkf_pkg::fx_t bias;
    abkf_pkg::fx_t rate;
  } estimate_t;

  // Scoreboard: holds the filter's own state and the queue of expected estimates.
  class kalman_scoreboard;
    abkf_pkg::cfg_t angle_noise;
    abkf_pkg::cfg_t bias_noise;
    abkf_pkg::cfg_t measure_noise;
    abkf_pkg::fx_t  angle_est [abkf_pkg::NUM_AXES];
    abkf_pkg::fx_t  bias_est [abkf_pkg::NUM_AXES];
    abkf_pkg::fx_t  c00 [abkf_pkg::NUM_AXES];
    abkf_pkg::fx_t  c01 [abkf_pkg::NUM_AXES];
    abkf_pkg::fx_t  c10 [abkf_pkg::NUM_AXES];
    abkf_pkg::fx_t  c11 [abkf_pkg::NUM_AXES];
    estimate_t      pending [$];
    int             errors;
    int             checked;

    function void clear();
      angle_noise   = abkf_pkg::ANGLE_NOISE_RESET;
      bias_noise    = abkf_pkg::BIAS_NOISE_RESET;
      measure_noise = abkf_pkg::MEASURE_NOISE_RESET;
      for (int k = 0; k < abkf_pkg::NUM_AXES; k++) begin
        angle_est[k] = '0;
        bias_est[k]  = '0;
        c00[k] = '0;
        c01[k] = '0;
        c10[k] = '0;
        c11[k] = '0;
      end
      pending.delete();
      errors  = 0;
      checked = 0;
    endfunction

    function void write_reg(abkf_pkg::cfg_idx_t idx, abkf_pkg::cfg_t val);
      case (idx)
        abkf_pkg::CFG_ANGLE_NOISE:   angle_noise = val;
        abkf_pkg::CFG_BIAS_NOISE:    bias_noise = val;
        abkf_pkg::CFG_MEASURE_NOISE: measure_noise = val;
        default: ;
      endcase
    endfunction

    static function abkf_pkg::fx_t clip(big_t v);
      big_t hi;
      big_t lo;
      hi = big_t'(abkf_pkg::FX_MAX);
      lo = big_t'(abkf_pkg::FX_MIN);
      if (v > hi) return abkf_pkg::FX_MAX;
      if (v < lo) return abkf_pkg::FX_MIN;
      return v[abkf_pkg::FX_W-1:0];
    endfunction

    // Product rounded on the magnitude, ties away from zero.
    static function abkf_pkg::fx_t mul_round(big_t a, big_t b);
      big_t p;
      logic neg;
      p = a * b;
      neg = p < 0;
      if (neg) p = -p;
      p = (p + (big_t'(1) <<< (abkf_pkg::FRAC_BITS - 1))) >>> abkf_pkg::FRAC_BITS;
      return clip(neg ? -p : p);
    endfunction

    // Quotient truncated toward zero, saturated.
    static function abkf_pkg::fx_t div_trunc(big_t n, big_t d);
      big_t q;
      logic neg;
      neg = (n < 0) != (d < 0);
      if (n < 0) n = -n;
      if (d < 0) d = -d;
      q = (n <<< abkf_pkg::FRAC_BITS) / d;
      return clip(neg ? -q : q);
    endfunction

    // Works out the result of one accepted sample and advances the state.
    function void note_sample(logic [abkf_pkg::AXIS_W-1:0] ax, abkf_pkg::fx_t gyro,
                              abkf_pkg::fx_t acc, logic [abkf_pkg::CFG_W-1:0] dt_in);
      estimate_t e;
      big_t x, b, diff, dt, t, p00, p01, p10, p11, den, k0, k1, innov;
      if (ax >= abkf_pkg::NUM_AXES) begin
        e.angle = '0;
        e.bias  = '0;
        e.rate  = '0;
        pending.push_back(e);
        return;
      end
      dt = big_t'({1'b0, dt_in});
      x = angle_est[ax];
      b = bias_est[ax];
      diff = big_t'(gyro) - b;
      e.rate = clip(diff);
      x = clip(x + mul_round(dt, diff));
      t = big_t'(c01[ax]) - mul_round(dt, c11[ax]);
      p00 = clip(big_t'(c00[ax]) - mul_round(dt, c10[ax]) - mul_round(dt, t)
                 + big_t'({1'b0, angle_noise}));
      p01 = clip(t);
      p10 = clip(big_t'(c10[ax]) - mul_round(dt, c11[ax]));
      p11 = clip(big_t'(c11[ax]) + big_t'({1'b0, bias_noise}));
      den = p00 + big_t'({1'b0, measure_noise});
      if (den == 0) begin
        k0 = 0;
        k1 = 0;
      end else begin
        k0 = div_trunc(p00, den);
        k1 = div_trunc(p10, den);
      end
      innov = big_t'(acc) - x;
      x = clip(x + mul_round(k0, innov));
      b = clip(b + mul_round(k1, innov));
      c00[ax] = clip(p00 - mul_round(k0, p00));
      c01[ax] = clip(p01 - mul_round(k0, p01));
      c10[ax] = clip(p10 - mul_round(k1, p00));
      c11[ax] = clip(p11 - mul_round(k1, p01));
      angle_est[ax] = x[abkf_pkg::FX_W-1:0];
      bias_est[ax]  = b[abkf_pkg::FX_W-1:0];
      e.angle = angle_est[ax];
      e.bias  = bias_est[ax];
      pending.push_back(e);
    endfunction

    function void check_estimate(abkf_pkg::fx_t angle, abkf_pkg::fx_t bias,
                                 abkf_pkg::fx_t rate);
      estimate_t e;
      if (pending.size() == 0) begin
        $error("unexpected result transaction: angle_out %0d", angle);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (angle !== e.angle) begin
        $error("angle_out: expected %0d, actual %0d", e.angle, angle);
        errors++;
      end
      if (bias !== e.bias) begin
        $error("bias_out: expected %0d, actual %0d", e.bias, bias);
        errors++;
      end
      if (rate !== e.rate) begin
        $error("unbiased_rate: expected %0d, actual %0d", e.rate, rate);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  abkf_pkg::cfg_idx_t cfg_index = '0;
  abkf_pkg::cfg_t     cfg_data = '0;
  bit                 calm = 1'b0;
  bit                 stim_done = 1'b0;
  int                 sent = 0;

  kalman_scoreboard board = new();

  abkf_in_if  in_ch ();
  abkf_out_if out_ch ();

  angle_bias_kalman_filter_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.axis = '0;
    in_ch.gyro_rate = '0;
    in_ch.accel_angle = '0;
    in_ch.time_step = '0;
    out_ch.ready = 1'b0;
  end

  // Receiver: random back-pressure except in calm stretches; checks at each transaction.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        board.check_estimate(out_ch.angle_out, out_ch.bias_out, out_ch.unbiased_rate);
      end
      out_ch.ready <= calm || ($urandom_range(99) >= 33);
    end
  end

  // One register write; the task returns with the write enable low.
  task automatic write_cfg(abkf_pkg::cfg_idx_t idx, abkf_pkg::cfg_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.write_reg(idx, val);
    @(posedge clk);
  endtask

  // Wait until every expected estimate has been received, plus a short settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Offers one sample and holds it until the transaction completes.
  task automatic send_sample(logic [abkf_pkg::AXIS_W-1:0] ax, abkf_pkg::fx_t gyro,
                             abkf_pkg::fx_t acc, logic [abkf_pkg::CFG_W-1:0] dt);
    while (!calm && $urandom_range(99) < 33) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.axis        <= ax;
    in_ch.gyro_rate   <= gyro;
    in_ch.accel_angle <= acc;
    in_ch.time_step   <= dt;
    do @(posedge clk); while (!in_ch.ready);
    board.note_sample(ax, gyro, acc, dt);
    sent++;
  endtask

  function automatic abkf_pkg::fx_t rand_fx(int scale);
    abkf_pkg::fx_t v;
    v = abkf_pkg::fx_t'({$urandom, $urandom});
    case (scale)
      0: v = abkf_pkg::fx_t'($signed(v[31:0])) >>> $urandom_range(8);
      1: v = abkf_pkg::fx_t'($signed(v[27:0]));
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [abkf_pkg::CFG_W-1:0] rand_dt();
    case ($urandom_range(9))
      0: return abkf_pkg::CFG_W'($urandom_range(1 << 24));
      1: return 25'h1FFFFFF;
      2: return '0;
      default: return abkf_pkg::CFG_W'($urandom_range(200000));
    endcase
  endfunction

  // Stimulus: directed corners, then random phases under several noise settings.
  initial begin
    abkf_pkg::cfg_t settings [5][3];
    int n;
    board.clear();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_sample(2'd0, '0, '0, '0);
    send_sample(2'd0, abkf_pkg::FX_MAX, abkf_pkg::FX_MAX, 25'h1000000);
    send_sample(2'd1, abkf_pkg::FX_MIN, abkf_pkg::FX_MIN, 25'h1FFFFFF);
    send_sample(2'd2, abkf_pkg::FX_MAX, abkf_pkg::FX_MIN, 25'h1000000);
    send_sample(2'd3, abkf_pkg::FX_MAX, abkf_pkg::FX_MAX, 25'h1000000);
    send_sample(2'd3, '1, '0, '1);
    send_sample(2'd2, abkf_pkg::FX_MIN, abkf_pkg::FX_MAX, 25'd16777);
    send_sample(2'd1, 40'sd16777216, -40'sd16777216, 25'd16777);
    send_sample(2'd0, -40'sd1, 40'sd1, 25'd1);
    drain();

    // Zero denominator: noise zero on a fresh axis reset gives p00 plus R hitting zero
    // only via a negative p00; drive the covariance negative with large steps.
    write_cfg(abkf_pkg::CFG_ANGLE_NOISE, '0);
    write_cfg(abkf_pkg::CFG_BIAS_NOISE, 25'h1000000);
    write_cfg(abkf_pkg::CFG_MEASURE_NOISE, 25'd1);
    for (int i = 0; i < 10; i++) begin
      send_sample(2'd2, rand_fx(2), rand_fx(2), 25'h1FFFFFF);
    end
    drain();

    settings = '{'{25'd16777, 25'd50332, 25'd50332},
                 '{25'd0, 25'd0, 25'd1},
                 '{25'h1000000, 25'h1000000, 25'h1000000},
                 '{25'h1FFFFFF, 25'h1FFFFFF, 25'h1FFFFFF},
                 '{25'd1000, 25'd3000, 25'd200000}};
    for (int ph = 0; ph < 5; ph++) begin
      write_cfg(abkf_pkg::CFG_ANGLE_NOISE, settings[ph][0]);
      write_cfg(abkf_pkg::CFG_BIAS_NOISE, settings[ph][1]);
      write_cfg(abkf_pkg::CFG_MEASURE_NOISE, settings[ph][2]);
      n = 0;
      calm = (ph == 2);
      while (n < 364) begin
        send_sample(($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2)),
                    rand_fx($urandom_range(2)), rand_fx($urandom_range(2)), rand_dt());
        n++;
      end
      calm = 1'b0;
      drain();
    end
    stim_done = 1'b1;
  end

  // Final report once all samples are in and every estimate has arrived.
  initial begin
    wait (stim_done);
    $display("Sent %0d samples over six noise settings; %0d estimates checked.",
             sent, board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("Timeout: run did not finish");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: files.f
sv/abkf_pkg.sv
sv/abkf_ifs.sv
sv/abkf_mul.sv
sv/abkf_div.sv
sv/abkf_ctrl.sv
sv/abkf_dpath.sv
sv/angle_bias_kalman_filter_core.sv
verif/tb_angle_bias_kalman_filter_core.sv
